/* hdl/serial_led_frame_parser_core_macros.svh */
// Assertion macros for the serial LED frame parser.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef SERIAL_LED_FRAME_PARSER_CORE_MACROS_SVH
`define SERIAL_LED_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define SLFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define SLFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* hdl/slfp_pkg.sv */
// Shared types and constants for the serial LED frame parser.
// No dependencies.
package slfp_pkg;

  typedef enum logic [1:0] {
    EV_PIXEL = 2'd0,
    EV_SHOW  = 2'd1,
    EV_BLANK = 2'd2,
    EV_ACK   = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    PH_EMPTY = 3'd0,
    PH_A     = 3'd1,
    PH_AD    = 3'd2,
    PH_ADA   = 3'd3,
    PH_CNTHI = 3'd4,
    PH_CNTLO = 3'd5,
    PH_DATA  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    REG_STRIP_LEN = 2'd0,
    REG_ACK_INT   = 2'd1,
    REG_TIMEOUT   = 2'd2
  } reg_idx_e;

  localparam logic [7:0]  HDR_A      = 8'h41;
  localparam logic [7:0]  HDR_D      = 8'h64;
  localparam logic [7:0]  HDR_LA     = 8'h61;
  localparam logic [7:0]  CHECK_MASK = 8'h55;
  localparam logic [16:0] STRIP_RST  = 17'd60;
  localparam logic [15:0] ACK_RST    = 16'd1000;
  localparam logic [15:0] TMO_RST    = 16'd1000;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [16:0] data;
  } cfg_wr_t;

  // one queue entry: up to two results caused by one item
  typedef struct packed {
    event_e      ev0;
    logic        has2;
    event_e      ev1;
    logic [15:0] idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
  } res_entry_t;

endpackage

/* hdl/slfp_front.sv */
// Front end: frame parser, tick timers and config registers.
// Turns each accepted item into at most one queue entry. Uses slfp_pkg.
module slfp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 kind_i,
  input  logic [7:0]           rx_byte_i,
  input  slfp_pkg::cfg_wr_t    cfg_i,
  output logic                 emit_o,
  output slfp_pkg::res_entry_t entry_o
);

  slfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  cnt_hi_q, cnt_hi_d, cnt_lo_q, cnt_lo_d;
  logic [16:0] pix_q, pix_d;
  logic [1:0]  pos_q, pos_d;
  logic [7:0]  red_q, red_d, grn_q, grn_d;
  logic [15:0] ack_tmr_q, ack_tmr_d, idle_tmr_q, idle_tmr_d;
  logic        started_q, started_d;
  logic [16:0] strip_q;
  logic [15:0] ack_int_q, tmo_q;

  logic [15:0] ack_inc, idle_inc;
  logic        ack_hit, blank_hit;
  logic [16:0] total, pix_nxt;
  logic [7:0]  wmin;
  logic        pix_on;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q   <= slfp_pkg::STRIP_RST;
      ack_int_q <= slfp_pkg::ACK_RST;
      tmo_q     <= slfp_pkg::TMO_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        slfp_pkg::REG_STRIP_LEN: strip_q   <= cfg_i.data;
        slfp_pkg::REG_ACK_INT:   ack_int_q <= cfg_i.data[15:0];
        slfp_pkg::REG_TIMEOUT:   tmo_q     <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= slfp_pkg::PH_EMPTY;
      cnt_hi_q   <= '0;
      cnt_lo_q   <= '0;
      pix_q      <= '0;
      pos_q      <= '0;
      red_q      <= '0;
      grn_q      <= '0;
      ack_tmr_q  <= '1;
      idle_tmr_q <= '0;
      started_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      cnt_hi_q   <= cnt_hi_d;
      cnt_lo_q   <= cnt_lo_d;
      pix_q      <= pix_d;
      pos_q      <= pos_d;
      red_q      <= red_d;
      grn_q      <= grn_d;
      ack_tmr_q  <= ack_tmr_d;
      idle_tmr_q <= idle_tmr_d;
      started_q  <= started_d;
    end
  end

  assign ack_inc   = (ack_tmr_q != '1) ? ack_tmr_q + 16'd1 : ack_tmr_q;
  assign idle_inc  = (idle_tmr_q != '1) ? idle_tmr_q + 16'd1 : idle_tmr_q;
  assign ack_hit   = (ack_inc >= ack_int_q);
  assign blank_hit = !started_q ||
                     ((phase_q != slfp_pkg::PH_EMPTY) && (idle_inc >= tmo_q));
  assign total     = {1'b0, cnt_hi_q, cnt_lo_q} + 17'd1;
  assign pix_nxt   = pix_q + 17'd1;
  assign pix_on    = (pix_q < strip_q);

  always_comb begin
    wmin = red_q;
    if (grn_q < wmin) wmin = grn_q;
    if (rx_byte_i < wmin) wmin = rx_byte_i;
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_hi_d   = cnt_hi_q;
    cnt_lo_d   = cnt_lo_q;
    pix_d      = pix_q;
    pos_d      = pos_q;
    red_d      = red_q;
    grn_d      = grn_q;
    ack_tmr_d  = ack_tmr_q;
    idle_tmr_d = idle_tmr_q;
    started_d  = started_q;
    emit_o     = 1'b0;
    entry_o    = '{ev0: slfp_pkg::EV_BLANK, has2: 1'b0, ev1: slfp_pkg::EV_BLANK,
                   idx: '0, red: '0, green: '0, blue: '0, white: '0};

    if (kind_i) begin
      ack_tmr_d  = ack_hit ? 16'd0 : ack_inc;
      idle_tmr_d = idle_inc;
      if (blank_hit) begin
        started_d = 1'b1;
        phase_d   = slfp_pkg::PH_EMPTY;
        pix_d     = '0;
        pos_d     = '0;
      end
      emit_o = ack_hit || blank_hit;
      if (ack_hit) begin
        entry_o.ev0  = slfp_pkg::EV_ACK;
        entry_o.has2 = blank_hit;
      end
    end else begin
      idle_tmr_d = '0;
      unique case (phase_q)
        slfp_pkg::PH_A: begin
          if (rx_byte_i == slfp_pkg::HDR_D) begin
            phase_d = slfp_pkg::PH_AD;
          end else begin
            phase_d = slfp_pkg::PH_EMPTY;
            pix_d   = '0;
            pos_d   = '0;
          end
        end
        slfp_pkg::PH_AD: begin
          if (rx_byte_i == slfp_pkg::HDR_LA) begin
            phase_d = slfp_pkg::PH_ADA;
          end else begin
            phase_d = slfp_pkg::PH_EMPTY;
            pix_d   = '0;
            pos_d   = '0;
          end
        end
        slfp_pkg::PH_ADA: begin
          cnt_hi_d = rx_byte_i;
          phase_d  = slfp_pkg::PH_CNTHI;
        end
        slfp_pkg::PH_CNTHI: begin
          cnt_lo_d = rx_byte_i;
          phase_d  = slfp_pkg::PH_CNTLO;
        end
        slfp_pkg::PH_CNTLO: begin
          phase_d = (rx_byte_i == (cnt_hi_q ^ cnt_lo_q ^ slfp_pkg::CHECK_MASK)) ?
                    slfp_pkg::PH_DATA : slfp_pkg::PH_EMPTY;
          pix_d   = '0;
          pos_d   = '0;
        end
        slfp_pkg::PH_DATA: begin
          case (pos_q)
            2'd0: begin
              red_d = rx_byte_i;
              pos_d = 2'd1;
            end
            2'd1: begin
              grn_d = rx_byte_i;
              pos_d = 2'd2;
            end
            default: begin
              pos_d = 2'd0;
              pix_d = pix_nxt;
              emit_o = pix_on || (pix_nxt >= total);
              if (pix_on) begin
                entry_o.ev0   = slfp_pkg::EV_PIXEL;
                entry_o.idx   = pix_q[15:0];
                entry_o.red   = red_q;
                entry_o.green = grn_q;
                entry_o.blue  = rx_byte_i;
                entry_o.white = wmin;
                entry_o.has2  = (pix_nxt >= total);
                entry_o.ev1   = slfp_pkg::EV_SHOW;
              end else begin
                entry_o.ev0 = slfp_pkg::EV_SHOW;
              end
              if (pix_nxt >= total) begin
                phase_d = slfp_pkg::PH_EMPTY;
                pix_d   = '0;
              end
            end
          endcase
        end
        default: begin
          phase_d = (rx_byte_i == slfp_pkg::HDR_A) ? slfp_pkg::PH_A : slfp_pkg::PH_EMPTY;
          pix_d   = '0;
          pos_d   = '0;
        end
      endcase
    end
  end

endmodule

/* hdl/slfp_queue.sv */
// Small register queue of result entries between front and back end.
// Uses slfp_pkg.
module slfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  slfp_pkg::res_entry_t wr_data_i,
  input  logic                 rd_i,
  output slfp_pkg::res_entry_t rd_data_o,
  output logic                 full_o,
  output logic                 nonempty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  slfp_pkg::res_entry_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && nonempty_o;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == LAST_PTR) ? '0 : wp_q + AW'(1);
      if (do_rd) rp_q <= (rp_q == LAST_PTR) ? '0 : rp_q + AW'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

/* hdl/slfp_back.sv */
// Back end: output register that unpacks queue entries into single results.
// Uses slfp_pkg.
module slfp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_nonempty_i,
  input  slfp_pkg::res_entry_t q_data_i,
  output logic                 q_rd_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [1:0]           event_res_o,
  output logic [15:0]          pixel_index_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic [7:0]           white_o,
  output logic                 last_o
);

  slfp_pkg::res_entry_t cur_q;
  logic valid_q, sub_q;
  logic xfer, done;

  assign xfer   = pop_i && valid_q;
  assign done   = sub_q || !cur_q.has2;
  assign q_rd_o = q_nonempty_i && (!valid_q || (xfer && done));

  always_ff @(posedge clk_i) begin
    if (q_rd_o) cur_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 1'b0;
    end else if (!valid_q || xfer) begin
      if (valid_q && !done) begin
        sub_q <= 1'b1;
      end else begin
        sub_q   <= 1'b0;
        valid_q <= q_nonempty_i;
      end
    end
  end

  assign empty_o       = !valid_q;
  assign event_res_o   = sub_q ? cur_q.ev1 : cur_q.ev0;
  assign pixel_index_o = sub_q ? '0 : cur_q.idx;
  assign red_o         = sub_q ? '0 : cur_q.red;
  assign green_o       = sub_q ? '0 : cur_q.green;
  assign blue_o        = sub_q ? '0 : cur_q.blue;
  assign white_o       = sub_q ? '0 : cur_q.white;
  assign last_o        = done;

endmodule

/* hdl/serial_led_frame_parser_core.sv */
// Serial LED frame parser, top level.
// Instantiates slfp_front, slfp_queue and slfp_back; uses slfp_pkg.
//
// Input channel (push/full): each transfer is either a received serial
// byte (kind_i = 0, rx_byte_i) or a one-millisecond tick (kind_i = 1).
// Result channel (empty/pop): pixel writes, show, blank-all and
// acknowledge events; last_o marks the final result of one input item.
// Config channel (cfg_valid_i/cfg_ready_o): always ready, index 0 strip
// length, 1 ack interval, 2 receive timeout; write only while idle.
// Throughput: one input item per cycle while full is low. A result passes
// through the queue and the output register on its way to the result ports;
// an item yielding two results occupies the output register for two pops.
// The parser handles one item per cycle and writes at most one entry into a
// QUEUE_DEPTH-entry queue; full rises when that queue is full, which
// happens only when the result receiver stalls.
// Reset: parser idle, strip length 60, both intervals 1000 ms, the first
// tick gives an acknowledge and a blank-all. Queue and output are emptied.
module serial_led_frame_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_res_o,
  output logic [15:0] pixel_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  white_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  slfp_pkg::cfg_wr_t    cfg_wr;
  slfp_pkg::res_entry_t f_entry, q_data;
  logic accept, f_emit, q_full, q_nonempty, q_rd;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = '{valid: cfg_valid_i, index: cfg_index_i, data: cfg_data_i};
  assign full        = q_full;
  assign accept      = push && !q_full;

  slfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .kind_i    (kind_i),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_wr),
    .emit_o    (f_emit),
    .entry_o   (f_entry)
  );

  slfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept && f_emit),
    .wr_data_i  (f_entry),
    .rd_i       (q_rd),
    .rd_data_o  (q_data),
    .full_o     (q_full),
    .nonempty_o (q_nonempty)
  );

  slfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_nonempty_i  (q_nonempty),
    .q_data_i      (q_data),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .event_res_o   (event_res_o),
    .pixel_index_o (pixel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .white_o       (white_o),
    .last_o        (last_o)
  );

endmodule

/* hdl/slfp_checker.sv */
// Port-level checker for the serial LED frame parser, bound to the top level.
// Uses slfp_pkg and serial_led_frame_parser_core_macros.svh.
`include "serial_led_frame_parser_core_macros.svh"

module slfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  event_res_o,
  input logic [15:0] pixel_index_o,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [7:0]  white_o,
  input logic        last_o
);

  `SLFP_ASSERT_NOW(a_white_min, !empty && event_res_o == slfp_pkg::EV_PIXEL, white_o <= red_o && white_o <= green_o && white_o <= blue_o && (white_o == red_o || white_o == green_o || white_o == blue_o))
  `SLFP_ASSERT_NOW(a_ctrl_zero, !empty && event_res_o != slfp_pkg::EV_PIXEL, pixel_index_o == 16'd0 && red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0 && white_o == 8'd0)
  `SLFP_ASSERT_NOW(a_show_last, !empty && (event_res_o == slfp_pkg::EV_SHOW || event_res_o == slfp_pkg::EV_BLANK), last_o)
  `SLFP_ASSERT_NEXT(a_ack_blank, !empty && pop && event_res_o == slfp_pkg::EV_ACK && !last_o, !empty && event_res_o == slfp_pkg::EV_BLANK)

endmodule

bind serial_led_frame_parser_core slfp_checker u_slfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .event_res_o   (event_res_o),
  .pixel_index_o (pixel_index_o),
  .red_o         (red_o),
  .green_o       (green_o),
  .blue_o        (blue_o),
  .white_o       (white_o),
  .last_o        (last_o)
);

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for serial_led_frame_parser_core.
// Needs slfp_pkg and the parser RTL; predicts every pixel, show, blank and ack event.
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    slfp_pkg::event_e ev;
    logic [15:0]      idx;
    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [7:0]       w;
    logic             last;
  } led_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        kind_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  event_res_o;
  logic [15:0] pixel_index_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  white_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [16:0] cfg_data_i = 17'd0;

  serial_led_frame_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .event_res_o   (event_res_o),
    .pixel_index_o (pixel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .white_o       (white_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser state mirror
  slfp_pkg::phase_e frm_phase;
  logic [7:0]  cnt_hi;
  logic [7:0]  cnt_lo;
  logic [16:0] px_cnt;
  logic [1:0]  byte_pos;
  logic [7:0]  hold_r;
  logic [7:0]  hold_g;
  logic [15:0] ack_ms;
  logic [15:0] idle_ms;
  logic        started_q;
  logic [16:0] strip_len;
  logic [15:0] ack_int;
  logic [15:0] rx_tmo;

  led_event_t due_events[$];
  int fail_count = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int seen_by_event[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  int stall_left = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;

  function automatic void model_reset();
    frm_phase = slfp_pkg::PH_EMPTY;
    cnt_hi = 8'h00;
    cnt_lo = 8'h00;
    px_cnt = 17'd0;
    byte_pos = 2'd0;
    hold_r = 8'h00;
    hold_g = 8'h00;
    ack_ms = 16'hFFFF;
    idle_ms = 16'h0000;
    started_q = 1'b0;
    strip_len = slfp_pkg::STRIP_RST;
    ack_int = slfp_pkg::ACK_RST;
    rx_tmo = slfp_pkg::TMO_RST;
  endfunction

  function automatic void drop_frame();
    frm_phase = slfp_pkg::PH_EMPTY;
    px_cnt = 17'd0;
    byte_pos = 2'd0;
  endfunction

  function automatic void add_event(slfp_pkg::event_e ev, logic [15:0] idx,
                                    logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                    logic [7:0] w);
    led_event_t e;
    e.ev = ev;
    e.idx = idx;
    e.r = r;
    e.g = g;
    e.b = b;
    e.w = w;
    e.last = 1'b0;
    due_events.insert(due_events.size(), e);
  endfunction

  function automatic void model_item(logic k, logic [7:0] b);
    int n_before;
    logic [16:0] total;
    logic [7:0] w;
    led_event_t e;
    n_before = due_events.size();
    if (k) begin
      if (ack_ms != 16'hFFFF) ack_ms++;
      if (idle_ms != 16'hFFFF) idle_ms++;
      if (ack_ms >= ack_int) begin
        add_event(slfp_pkg::EV_ACK, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        ack_ms = 16'd0;
      end
      if (!started_q) begin
        started_q = 1'b1;
        drop_frame();
        add_event(slfp_pkg::EV_BLANK, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      end else if (frm_phase != slfp_pkg::PH_EMPTY && idle_ms >= rx_tmo) begin
        drop_frame();
        add_event(slfp_pkg::EV_BLANK, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      end
    end else begin
      idle_ms = 16'd0;
      case (frm_phase)
        slfp_pkg::PH_A: begin
          if (b == slfp_pkg::HDR_D) frm_phase = slfp_pkg::PH_AD;
          else drop_frame();
        end
        slfp_pkg::PH_AD: begin
          if (b == slfp_pkg::HDR_LA) frm_phase = slfp_pkg::PH_ADA;
          else drop_frame();
        end
        slfp_pkg::PH_ADA: begin
          cnt_hi = b;
          frm_phase = slfp_pkg::PH_CNTHI;
        end
        slfp_pkg::PH_CNTHI: begin
          cnt_lo = b;
          frm_phase = slfp_pkg::PH_CNTLO;
        end
        slfp_pkg::PH_CNTLO: begin
          if (b == (cnt_hi ^ cnt_lo ^ slfp_pkg::CHECK_MASK)) begin
            frm_phase = slfp_pkg::PH_DATA;
            px_cnt = 17'd0;
            byte_pos = 2'd0;
          end else begin
            drop_frame();
          end
        end
        slfp_pkg::PH_DATA: begin
          if (byte_pos == 2'd0) begin
            hold_r = b;
            byte_pos = 2'd1;
          end else if (byte_pos == 2'd1) begin
            hold_g = b;
            byte_pos = 2'd2;
          end else begin
            total = {1'b0, cnt_hi, cnt_lo} + 17'd1;
            w = hold_r;
            if (hold_g < w) w = hold_g;
            if (b < w) w = b;
            if (px_cnt < strip_len)
              add_event(slfp_pkg::EV_PIXEL, px_cnt[15:0], hold_r, hold_g, b, w);
            px_cnt = px_cnt + 17'd1;
            byte_pos = 2'd0;
            if (px_cnt >= total) begin
              add_event(slfp_pkg::EV_SHOW, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
              drop_frame();
            end
          end
        end
        default: begin
          if (b == slfp_pkg::HDR_A) begin
            frm_phase = slfp_pkg::PH_A;
            px_cnt = 17'd0;
            byte_pos = 2'd0;
          end else begin
            drop_frame();
          end
        end
      endcase
    end
    if (due_events.size() > n_before) begin
      e = due_events[due_events.size() - 1];
      e.last = 1'b1;
      due_events[due_events.size() - 1] = e;
    end
  endfunction

  // mostly short, sometimes long
  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic next_pop();
    int n;
    if (stall_left > 0) begin
      stall_left--;
      return 1'b0;
    end
    if (!stalls_on) return 1'b1;
    n = pick_span();
    if (n == 0) return 1'b1;
    stall_left = n - 1;
    return 1'b0;
  endfunction

  function automatic void check_result();
    led_event_t got;
    led_event_t want;
    got.ev = slfp_pkg::event_e'(event_res_o);
    got.idx = pixel_index_o;
    got.r = red_o;
    got.g = green_o;
    got.b = blue_o;
    got.w = white_o;
    got.last = last_o;
    seen_by_event[event_res_o]++;
    if (due_events.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: unexpected result ev=%0d idx=%0d", $time, event_res_o,
                 pixel_index_o);
      return;
    end
    want = due_events.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("%0t: mismatch exp ev=%0d idx=%0d rgbw=%0d/%0d/%0d/%0d last=%0d",
                 $time, want.ev, want.idx, want.r, want.g, want.b, want.w, want.last);
        $display("%0t:          got ev=%0d idx=%0d rgbw=%0d/%0d/%0d/%0d last=%0d",
                 $time, got.ev, got.idx, got.r, got.g, got.b, got.w, got.last);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result();
      pop <= next_pop();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, due_events.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    gap = gaps_on ? pick_span() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    kind_i <= k;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    model_item(k, b);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_item(1'b0, seq[i]);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input slfp_pkg::reg_idx_e idx, input logic [16:0] data);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      slfp_pkg::REG_STRIP_LEN: strip_len = data;
      slfp_pkg::REG_ACK_INT:   ack_int = data[15:0];
      default:                 rx_tmo = data[15:0];
    endcase
    cfg_writes++;
  endtask

  function automatic logic [7:0] rand_color();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // header, count, checksum, then colors; bad_pos flips one byte, stop cuts it short
  task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo, input int bad_pos,
                            input int stop, input int tick_pct);
    logic [7:0] hdr[6];
    logic [7:0] b;
    int n;
    hdr = '{slfp_pkg::HDR_A, slfp_pkg::HDR_D, slfp_pkg::HDR_LA, hi, lo,
            hi ^ lo ^ slfp_pkg::CHECK_MASK};
    n = 6 + 3 * ({hi, lo} + 1);
    if (stop >= 0 && stop < n) n = stop;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 99) < tick_pct) send_tick();
      b = (i < 6) ? hdr[i] : rand_color();
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_item(1'b0, b);
    end
  endtask

  task automatic test_bytes_before_first_tick();
    send_bytes('{slfp_pkg::HDR_A, slfp_pkg::HDR_D, slfp_pkg::HDR_LA, 8'h00, 8'h00,
                 slfp_pkg::CHECK_MASK, 8'hFF, 8'h00, 8'h80});
    send_bytes('{slfp_pkg::HDR_A, slfp_pkg::HDR_D});
    send_item(1'b1, 8'hFF);
    send_item(1'b0, slfp_pkg::HDR_LA);
  endtask

  task automatic test_header_faults();
    send_bytes('{slfp_pkg::HDR_A, 8'h78, slfp_pkg::HDR_A, slfp_pkg::HDR_D, 8'h00});
    send_bytes('{slfp_pkg::HDR_A, slfp_pkg::HDR_A, slfp_pkg::HDR_D, slfp_pkg::HDR_LA});
    send_bytes('{slfp_pkg::HDR_A, slfp_pkg::HDR_D, slfp_pkg::HDR_LA, 8'h00, 8'h00, 8'h54});
    write_reg(slfp_pkg::REG_STRIP_LEN, 17'd1);
    send_bytes('{slfp_pkg::HDR_A, slfp_pkg::HDR_D, slfp_pkg::HDR_LA, 8'h00, 8'h01, 8'h54,
                 8'hFF, 8'h80, 8'h00, 8'h05, 8'h06, 8'h07});
  endtask

  task automatic test_interval_limits();
    write_reg(slfp_pkg::REG_ACK_INT, 17'd0);
    write_reg(slfp_pkg::REG_TIMEOUT, 17'd0);
    send_tick();
    send_item(1'b0, slfp_pkg::HDR_A);
    send_tick();
    write_reg(slfp_pkg::REG_ACK_INT, 17'h1FFFF);
    write_reg(slfp_pkg::REG_TIMEOUT, 17'd3);
    send_item(1'b0, slfp_pkg::HDR_A);
    repeat (3) send_tick();
    write_reg(slfp_pkg::REG_STRIP_LEN, 17'd0);
    send_bytes('{slfp_pkg::HDR_A, slfp_pkg::HDR_D, slfp_pkg::HDR_LA, 8'h00, 8'h00,
                 slfp_pkg::CHECK_MASK, 8'h01, 8'h02, 8'h03});
  endtask

  // count 0xFFFF means 65536 LEDs; the frame is cut short and left to time out
  task automatic test_full_count_frame();
    write_reg(slfp_pkg::REG_STRIP_LEN, 17'h1FFFF);
    write_reg(slfp_pkg::REG_TIMEOUT, 17'd3);
    send_frame(8'hFF, 8'hFF, -1, 30, 0);
    repeat (4) send_tick();
    write_reg(slfp_pkg::REG_STRIP_LEN, 17'd65536);
    send_frame(8'h00, 8'h02, -1, -1, 0);
  endtask

  function automatic logic [16:0] pick_strip();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd65536;
      3: return 17'h1FFFF;
      4: return 17'(slfp_pkg::STRIP_RST);
      default: return 17'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [16:0] pick_interval();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'h1FFFF;
      3: return 17'd65535;
      default: return 17'($urandom_range(2, 25));
    endcase
  endfunction

  function automatic int small_count();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 20);
  endfunction

  task automatic random_sequence();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      send_frame(8'h00, 8'(small_count()), -1, -1, 8);
    end else if (r < 74) begin
      k = $urandom_range(0, 5);
      send_frame(8'($urandom), 8'($urandom), k, k + 1 + $urandom_range(0, 3), 5);
    end else if (r < 82) begin
      send_frame(8'h00, 8'(small_count()), -1, $urandom_range(1, 12), 0);
      repeat ($urandom_range(1, 6)) send_tick();
    end else if (r < 92) begin
      repeat ($urandom_range(1, 4)) send_tick();
    end else begin
      repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(slfp_pkg::REG_STRIP_LEN, pick_strip());
      write_reg(slfp_pkg::REG_ACK_INT, pick_interval());
      write_reg(slfp_pkg::REG_TIMEOUT, pick_interval());
      gaps_on = (ph % 3) != 0;
      stalls_on = (ph % 2) != 0;
      goal = items_sent + 130;
      while (items_sent < goal) random_sequence();
    end
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_bytes_before_first_tick();
    test_header_faults();
    test_interval_limits();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    test_full_count_frame();
    test_random_traffic();
    wait_drain();
    $display("Sent %0d input transfers and %0d register writes", items_sent, cfg_writes);
    $display("Checked %0d pixel, %0d show, %0d blank and %0d ack results",
             seen_by_event[slfp_pkg::EV_PIXEL], seen_by_event[slfp_pkg::EV_SHOW],
             seen_by_event[slfp_pkg::EV_BLANK], seen_by_event[slfp_pkg::EV_ACK]);
    if (fail_count == 0 && due_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, due_events.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/slfp_pkg.sv
hdl/slfp_front.sv
hdl/slfp_queue.sv
hdl/slfp_back.sv
hdl/serial_led_frame_parser_core.sv
hdl/slfp_checker.sv
verif/testbench.sv
